FILE: rtl/wtg_pkg.sv
// ----------------------------------------------------------------------------
// Water table gradient package
// Field widths, saturation limits and reset values shared by the interfaces
// and the gradient unit.
// ----------------------------------------------------------------------------
package wtg_pkg;

   // Widths of the transaction fields.
   localparam int ELEV_W  = 32;
   localparam int SHARE_W = 32;
   localparam int EPS_W   = 16;
   localparam int SAT_W   = 40;

   // Default number of fraction bits in the share formats.
   localparam int SHARE_FRAC_BITS_DEF = 16;

   // Reset value of the elevation epsilon register.
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

   // Largest value of the saturating share and sum formats.
   localparam logic [SAT_W-1:0] SAT_MAX = {SAT_W{1'b1}};

endpackage

FILE: rtl/wtg_intf.sv
// ----------------------------------------------------------------------------
// Water table gradient channel interfaces
// Request, response and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------

// Neighbour request channel.
interface wtg_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [wtg_pkg::ELEV_W-1:0]   center_elevation;
   logic signed [wtg_pkg::ELEV_W-1:0]   center_sat_deficit;
   logic signed [wtg_pkg::ELEV_W-1:0]   neighbor_elevation;
   logic signed [wtg_pkg::ELEV_W-1:0]   neighbor_sat_deficit;
   logic        [wtg_pkg::SHARE_W-1:0]  neighbor_share;
   logic        [wtg_pkg::SHARE_W-1:0]  total_share;
   logic                                last_neighbor;
   logic                                no_neighbors;

   modport source (
      output valid, center_elevation, center_sat_deficit, neighbor_elevation,
             neighbor_sat_deficit, neighbor_share, total_share, last_neighbor,
             no_neighbors,
      input  ready
   );

   modport sink (
      input  valid, center_elevation, center_sat_deficit, neighbor_elevation,
             neighbor_sat_deficit, neighbor_share, total_share, last_neighbor,
             no_neighbors,
      output ready
   );
endinterface

// Adjusted share response channel.
interface wtg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [wtg_pkg::SAT_W-1:0]         adjusted_share;
   logic                              saturated;

   modport source (output valid, adjusted_share, saturated, input ready);
   modport sink   (input valid, adjusted_share, saturated, output ready);
endinterface

// Register write channel for the elevation epsilon.
interface wtg_csr_if;
   logic                              valid;
   logic                              ready;
   logic [wtg_pkg::EPS_W-1:0]         elevation_epsilon;

   modport source (output valid, elevation_epsilon, input ready);
   modport sink   (input valid, elevation_epsilon, output ready);
endinterface

FILE: rtl/water_table_gradient_gamma_unit.sv
// ----------------------------------------------------------------------------
// Water table gradient gamma unit
// Accumulates clipped water table gradient ratios over the neighbours of a
// patch and scales the patch total share by the sum on the last neighbour.
// ----------------------------------------------------------------------------
// Neighbours are accepted only while the sequencer is idle, so each one is
// finished before the next is taken. A neighbour that contributes a term
// passes the restoring divider (unless the ratio clips) and the shift-add
// multiplier; a patch without neighbours goes straight to the response. On a
// contributing last neighbour the multiplier runs twice.
// Reset clears the sequencer, the sum, the clip flag and the response valid,
// and sets the elevation epsilon to 1.
module water_table_gradient_gamma_unit #(
   parameter int SHARE_FRAC_BITS = wtg_pkg::SHARE_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   wtg_req_if.sink     req_ch,
   wtg_rsp_if.source   rsp_ch,
   wtg_csr_if.sink     csr_ch
);

   // Widths derived from the field widths and the share fraction.
   localparam int ELEV_W    = wtg_pkg::ELEV_W;
   localparam int SHARE_W   = wtg_pkg::SHARE_W;
   localparam int EPS_W     = wtg_pkg::EPS_W;
   localparam int SAT_W     = wtg_pkg::SAT_W;
   localparam int DZ_W      = ELEV_W + 1;          // elevation difference
   localparam int WT_W      = ELEV_W + 2;          // water table
   localparam int DW_W      = ELEV_W + 3;          // water table difference
   localparam int AW_W      = ELEV_W + 2;          // magnitude of that difference
   localparam int NUM_W     = AW_W + SHARE_FRAC_BITS;
   localparam int ACC_W     = SAT_W + SHARE_W;
   localparam int DIV_STEPS = SAT_W;
   localparam int MUL_STEPS = SHARE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS > MUL_STEPS ? DIV_STEPS : MUL_STEPS);

   // Sequencer states.
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_WT    = 10'b0000000010,
      ST_DIFF  = 10'b0000000100,
      ST_TEST  = 10'b0000001000,
      ST_OVF   = 10'b0000010000,
      ST_DIV   = 10'b0000100000,
      ST_MUL   = 10'b0001000000,
      ST_MDONE = 10'b0010000000,
      ST_TAIL  = 10'b0100000000,
      ST_EMIT  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [EPS_W-1:0] eps_ff, eps_in;

   // Captured transaction fields.
   logic signed [ELEV_W-1:0] cz_ff, cz_in, cd_ff, cd_in, nz_ff, nz_in, nd_ff, nd_in;
   logic [SHARE_W-1:0]       nshare_ff, nshare_in, total_ff, total_in;
   logic                     last_ff, last_in;

   // Difference datapath.
   logic signed [WT_W-1:0] wtc_ff, wtc_in, wtn_ff, wtn_in;
   logic signed [DZ_W-1:0] dz_ff, dz_in;
   logic signed [DW_W-1:0] dw_ff, dw_in;
   logic [DZ_W-1:0]        adz_ff, adz_in;
   logic [AW_W-1:0]        adw_ff, adw_in;

   // Divider and multiplier shift registers.
   logic [DZ_W-1:0]  rem_ff, rem_in;
   logic [SAT_W-1:0] quo_ff, quo_in;
   logic [SAT_W-1:0] mcand_ff, mcand_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             fin_ff, fin_in;

   // Running sum and clip flag.
   logic [SAT_W-1:0] sum_ff, sum_in;
   logic             clip_ff, clip_in;

   // Pending result and response register.
   logic [SAT_W-1:0] res_ff, res_in;
   logic             res_sat_ff, res_sat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SAT_W-1:0] rsp_share_ff, rsp_share_in;
   logic             rsp_sat_ff, rsp_sat_in;

   // Combinational helpers.
   logic signed [DZ_W-1:0] eps_s;
   logic                   cd_gt, nd_gt;
   logic                   use_term;
   logic [NUM_W-1:0]       num, num_hi;
   logic                   div_ovf;
   logic [DZ_W:0]          trial;
   logic                   trial_ge;
   logic [SAT_W:0]         mul_add;
   logic [ACC_W-1:0]       prod_sh;
   logic                   prod_sat;
   logic [SAT_W-1:0]       prod_val;
   logic [SAT_W:0]         sum_add;
   logic                   req_acc;

   assign req_acc = req_ch.valid && req_ch.ready;

   // Deficit tests against the epsilon, in signed arithmetic.
   assign eps_s = $signed({{(DZ_W-EPS_W){1'b0}}, eps_ff});
   assign cd_gt = $signed(DZ_W'(cd_ff)) > eps_s;
   assign nd_gt = $signed(DZ_W'(nd_ff)) > eps_s;

   // A neighbour counts when it is not flat and the gradient is positive.
   assign use_term = (adz_ff > {{(DZ_W-EPS_W){1'b0}}, eps_ff})
                     && (dw_ff[DW_W-1] == dz_ff[DZ_W-1]) && (dw_ff != '0);

   // Scaled dividend; the quotient saturates when its upper part reaches adz.
   assign num     = NUM_W'(adw_ff) << SHARE_FRAC_BITS;
   assign num_hi  = num >> SAT_W;
   assign div_ovf = num_hi >= NUM_W'(adz_ff);

   // One restoring division step.
   assign trial    = {rem_ff, quo_ff[SAT_W-1]};
   assign trial_ge = trial >= {1'b0, adz_ff};

   // One shift-add multiplication step.
   assign mul_add = {1'b0, acc_ff[ACC_W-1:SHARE_W]}
                    + (acc_ff[0] ? {1'b0, mcand_ff} : '0);

   // Product scaling and saturation.
   assign prod_sh  = acc_ff >> SHARE_FRAC_BITS;
   assign prod_sat = |prod_sh[ACC_W-1:SAT_W];
   assign prod_val = prod_sat ? wtg_pkg::SAT_MAX : prod_sh[SAT_W-1:0];
   assign sum_add  = {1'b0, sum_ff} + {1'b0, prod_val};

   // Sequencer and datapath next state.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      eps_in       = eps_ff;
      cz_in        = cz_ff;
      cd_in        = cd_ff;
      nz_in        = nz_ff;
      nd_in        = nd_ff;
      nshare_in    = nshare_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      wtc_in       = wtc_ff;
      wtn_in       = wtn_ff;
      dz_in        = dz_ff;
      dw_in        = dw_ff;
      adz_in       = adz_ff;
      adw_in       = adw_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      mcand_in     = mcand_ff;
      acc_in       = acc_ff;
      fin_in       = fin_ff;
      sum_in       = sum_ff;
      clip_in      = clip_ff;
      res_in       = res_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_share_in = rsp_share_ff;
      rsp_sat_in   = rsp_sat_ff;

      // Register writes.
      if (csr_ch.valid && csr_ch.ready) begin
         eps_in = csr_ch.elevation_epsilon;
      end

      // The response register drains independently of the sequencer.
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               cz_in     = req_ch.center_elevation;
               cd_in     = req_ch.center_sat_deficit;
               nz_in     = req_ch.neighbor_elevation;
               nd_in     = req_ch.neighbor_sat_deficit;
               nshare_in = req_ch.neighbor_share;
               total_in  = req_ch.total_share;
               last_in   = req_ch.last_neighbor;
               if (req_ch.no_neighbors) begin
                  sum_in     = '0;
                  clip_in    = 1'b0;
                  res_in     = SAT_W'(req_ch.total_share);
                  res_sat_in = 1'b0;
                  state_in   = ST_EMIT;
               end else begin
                  state_in = ST_WT;
               end
            end
         end
         ST_WT: begin
            wtc_in   = cd_gt ? WT_W'(cz_ff) - WT_W'(cd_ff) : WT_W'(cz_ff);
            wtn_in   = nd_gt ? WT_W'(nz_ff) - WT_W'(nd_ff) : WT_W'(nz_ff);
            dz_in    = DZ_W'(cz_ff) - DZ_W'(nz_ff);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dw_in    = DW_W'(wtc_ff) - DW_W'(wtn_ff);
            adz_in   = dz_ff[DZ_W-1] ? DZ_W'(-dz_ff) : DZ_W'(dz_ff);
            state_in = ST_TEST;
         end
         ST_TEST: begin
            adw_in   = dw_ff[DW_W-1] ? AW_W'(-dw_ff) : AW_W'(dw_ff);
            state_in = use_term ? ST_OVF : ST_TAIL;
         end
         ST_OVF: begin
            if (div_ovf) begin
               // The ratio clips; go straight to the multiplier.
               clip_in  = 1'b1;
               mcand_in = wtg_pkg::SAT_MAX;
               acc_in   = {{SAT_W{1'b0}}, nshare_ff};
               fin_in   = 1'b0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end else begin
               rem_in   = num_hi[DZ_W-1:0];
               quo_in   = num[SAT_W-1:0];
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? DZ_W'(trial - {1'b0, adz_ff}) : trial[DZ_W-1:0];
            quo_in = {quo_ff[SAT_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               mcand_in = {quo_ff[SAT_W-2:0], trial_ge};
               acc_in   = {{SAT_W{1'b0}}, nshare_ff};
               fin_in   = 1'b0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in = {mul_add, acc_ff[SHARE_W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_MDONE;
            end
         end
         ST_MDONE: begin
            if (fin_ff) begin
               res_in     = prod_val;
               res_sat_in = clip_ff | prod_sat;
               sum_in     = '0;
               clip_in    = 1'b0;
               state_in   = ST_EMIT;
            end else begin
               sum_in   = sum_add[SAT_W] ? wtg_pkg::SAT_MAX : sum_add[SAT_W-1:0];
               clip_in  = clip_ff | prod_sat | sum_add[SAT_W];
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (last_ff) begin
               mcand_in = sum_ff;
               acc_in   = {{SAT_W{1'b0}}, total_ff};
               fin_in   = 1'b1;
               cnt_in   = '0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_share_in = res_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         eps_ff       <= wtg_pkg::EPS_RESET;
         sum_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         eps_ff       <= eps_in;
         sum_ff       <= sum_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cz_ff        <= cz_in;
      cd_ff        <= cd_in;
      nz_ff        <= nz_in;
      nd_ff        <= nd_in;
      nshare_ff    <= nshare_in;
      total_ff     <= total_in;
      last_ff      <= last_in;
      wtc_ff       <= wtc_in;
      wtn_ff       <= wtn_in;
      dz_ff        <= dz_in;
      dw_ff        <= dw_in;
      adz_ff       <= adz_in;
      adw_ff       <= adw_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      mcand_ff     <= mcand_in;
      acc_ff       <= acc_in;
      fin_ff       <= fin_in;
      res_ff       <= res_in;
      res_sat_ff   <= res_sat_in;
      rsp_share_ff <= rsp_share_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // Port drive.
   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.adjusted_share = rsp_share_ff;
   assign rsp_ch.saturated      = rsp_sat_ff;

   // The partial remainder stays below the divisor throughout the division.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < adz_ff))
      else $error("divider remainder not below divisor");

   // The multiplier never runs past its last step.
   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (cnt_ff < CNT_W'(MUL_STEPS)))
      else $error("multiplier step count out of range");

   // A result waits only with the per-patch state already cleared.
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (sum_ff == '0 && !clip_ff))
      else $error("patch state not cleared at result");

   // A patch without neighbours goes straight to the result, unsaturated.
   a_no_neighbors: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_ch.no_neighbors) |=> (state_ff == ST_EMIT && !res_sat_ff))
      else $error("patch without neighbours not passed through");

endmodule

FILE: tb/wtg_share_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjusted share checker
// Watches the request, response and register write channels of the gradient
// gamma unit, predicts the adjusted share of each patch from the accepted
// transactions and compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
module wtg_share_checker (
   input  logic clock,
   input  logic reset,
   wtg_req_if   req_ch,
   wtg_rsp_if   rsp_ch,
   wtg_csr_if   csr_ch,
   output int   error_count,
   output int   pending_count
);
   import wtg_pkg::*;

   localparam int SHARE_FRAC = SHARE_FRAC_BITS_DEF;

   typedef struct packed {
      logic [SAT_W-1:0] adjusted_share;
      logic             saturated;
   } share_result_t;

   // Predicted responses in arrival order, plus the predictor's own state.
   share_result_t    expected_shares[$];
   logic [EPS_W-1:0] epsilon;
   logic [SAT_W-1:0] gradient_sum;
   bit               clip_flag;

   initial error_count = 0;

   // Water table: the deficit only counts when it exceeds the epsilon.
   function automatic longint water_level(input longint z, input longint d);
      return (d > longint'(epsilon)) ? z - d : z;
   endfunction

   // Fixed-point product of two shares, clipped to the 40-bit range.
   function automatic logic [SAT_W-1:0] scale_share(input logic [SAT_W-1:0] a,
                                                    input logic [SAT_W-1:0] b,
                                                    inout bit clip);
      logic [2*SAT_W-1:0] product;
      product = ({{SAT_W{1'b0}}, a} * {{SAT_W{1'b0}}, b}) >> SHARE_FRAC;
      if (product > {{SAT_W{1'b0}}, SAT_MAX}) begin
         clip = 1'b1;
         return SAT_MAX;
      end
      return product[SAT_W-1:0];
   endfunction

   // Adds the gradient term of one neighbour to the running sum.
   function automatic void accumulate_gradient(input longint cz, input longint cd,
                                               input longint nz, input longint nd,
                                               input logic [SAT_W-1:0] nshare);
      longint           dz;
      longint           dw;
      logic [63:0]      abs_dz;
      logic [63:0]      abs_dw;
      logic [63:0]      ratio;
      logic [SAT_W-1:0] term;
      logic [SAT_W:0]   wide_sum;
      dz = cz - nz;
      abs_dz = (dz < 0) ? -dz : dz;
      // A flat neighbour adds nothing.
      if (abs_dz <= {48'd0, epsilon})
         return;
      dw = water_level(cz, cd) - water_level(nz, nd);
      // A gradient against the slope is clipped to zero without raising the flag.
      if (dw == 0 || ((dw < 0) != (dz < 0)))
         return;
      abs_dw = (dw < 0) ? -dw : dw;
      ratio = (abs_dw << SHARE_FRAC) / abs_dz;
      if (ratio > {24'd0, SAT_MAX}) begin
         ratio = {24'd0, SAT_MAX};
         clip_flag = 1'b1;
      end
      term = scale_share(ratio[SAT_W-1:0], nshare, clip_flag);
      wide_sum = {1'b0, gradient_sum} + {1'b0, term};
      if (wide_sum[SAT_W]) begin
         gradient_sum = SAT_MAX;
         clip_flag = 1'b1;
      end else begin
         gradient_sum = wide_sum[SAT_W-1:0];
      end
   endfunction

   // Updates the prediction for one accepted request transaction.
   function automatic void predict_request();
      share_result_t res;
      if (req_ch.no_neighbors) begin
         res.adjusted_share = SAT_W'(req_ch.total_share);
         res.saturated = 1'b0;
         expected_shares.push_back(res);
         gradient_sum = '0;
         clip_flag = 1'b0;
         return;
      end
      accumulate_gradient(longint'(req_ch.center_elevation),
                          longint'(req_ch.center_sat_deficit),
                          longint'(req_ch.neighbor_elevation),
                          longint'(req_ch.neighbor_sat_deficit),
                          SAT_W'(req_ch.neighbor_share));
      if (!req_ch.last_neighbor)
         return;
      res.adjusted_share = scale_share(SAT_W'(req_ch.total_share), gradient_sum, clip_flag);
      res.saturated = clip_flag;
      expected_shares.push_back(res);
      gradient_sum = '0;
      clip_flag = 1'b0;
   endfunction

   // Compares one accepted response transaction with the oldest prediction.
   function automatic void check_response();
      share_result_t want;
      if (expected_shares.size() == 0) begin
         $error("Unexpected response: adjusted_share %0h, saturated %0b",
                rsp_ch.adjusted_share, rsp_ch.saturated);
         error_count++;
         return;
      end
      want = expected_shares.pop_front();
      if (rsp_ch.adjusted_share !== want.adjusted_share) begin
         $error("adjusted_share mismatch: expected %0h, actual %0h",
                want.adjusted_share, rsp_ch.adjusted_share);
         error_count++;
      end
      if (rsp_ch.saturated !== want.saturated) begin
         $error("saturated mismatch: expected %0b, actual %0b",
                want.saturated, rsp_ch.saturated);
         error_count++;
      end
   endfunction

   // Responses are checked before requests so that a spurious response can
   // never consume a prediction made at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         epsilon = EPS_RESET;
         gradient_sum = '0;
         clip_flag = 1'b0;
         expected_shares.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_response();
         if (csr_ch.valid && csr_ch.ready)
            epsilon = csr_ch.elevation_epsilon;
         if (req_ch.valid && req_ch.ready)
            predict_request();
      end
      pending_count = expected_shares.size();
   end

endmodule

FILE: tb/tb_water_table_gradient_gamma_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water table gradient gamma unit testbench
// Streams directed and random neighbour transactions into the unit under
// several epsilon settings and idle patterns; the share checker predicts and
// compares the responses, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_water_table_gradient_gamma_unit;
   import wtg_pkg::*;

   typedef struct {
      logic signed [ELEV_W-1:0] center_elevation;
      logic signed [ELEV_W-1:0] center_sat_deficit;
      logic signed [ELEV_W-1:0] neighbor_elevation;
      logic signed [ELEV_W-1:0] neighbor_sat_deficit;
      logic [SHARE_W-1:0]       neighbor_share;
      logic [SHARE_W-1:0]       total_share;
      logic                     last_neighbor;
      logic                     no_neighbors;
   } neighbor_item_t;

   localparam int SETTLE_CYCLES = 150;
   localparam int LONG_HOLD_CYCLES = 600;

   logic             clock;
   logic             reset;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               hold_len;
   bit               hold_start;
   int               items_sent;
   logic [EPS_W-1:0] epsilon_now;
   int               error_count;
   int               pending_count;

   wtg_req_if req_ch();
   wtg_rsp_if rsp_ch();
   wtg_csr_if csr_ch();

   water_table_gradient_gamma_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   wtg_share_checker share_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Clock generation.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog for a hung run.
   initial begin
      #15_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Response ready, with random stalls and an occasional long hold-off.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (hold_len) @(negedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic neighbor_item_t make_item(input logic signed [ELEV_W-1:0] cz,
                                                input logic signed [ELEV_W-1:0] cd,
                                                input logic signed [ELEV_W-1:0] nz,
                                                input logic signed [ELEV_W-1:0] nd,
                                                input logic [SHARE_W-1:0] nshare,
                                                input logic [SHARE_W-1:0] tshare,
                                                input logic is_last,
                                                input logic is_alone);
      neighbor_item_t item;
      item.center_elevation = cz;
      item.center_sat_deficit = cd;
      item.neighbor_elevation = nz;
      item.neighbor_sat_deficit = nd;
      item.neighbor_share = nshare;
      item.total_share = tshare;
      item.last_neighbor = is_last;
      item.no_neighbors = is_alone;
      return item;
   endfunction

   function automatic logic signed [ELEV_W-1:0] pick_elevation();
      case ($urandom_range(9))
         0:       return {1'b1, {(ELEV_W-1){1'b0}}};
         1:       return {1'b0, {(ELEV_W-1){1'b1}}};
         2, 3:    return $urandom();
         default: return ELEV_W'(int'($urandom_range(0, 2000000)) - 1000000);
      endcase
   endfunction

   // Neighbour elevation, mostly near the centre and often near the flat limit.
   function automatic logic signed [ELEV_W-1:0] near_elevation(
         input logic signed [ELEV_W-1:0] cz);
      int offset;
      case ($urandom_range(9))
         0, 1: offset = int'($urandom_range(0, 2 * epsilon_now + 4)) - int'(epsilon_now) - 2;
         2:    return $urandom();
         default: offset = int'($urandom_range(0, 200000)) - 100000;
      endcase
      return cz + offset;
   endfunction

   function automatic logic signed [ELEV_W-1:0] pick_deficit();
      case ($urandom_range(6))
         0:       return ELEV_W'(-int'($urandom_range(0, 100000)));
         1:       return '0;
         2:       return ELEV_W'(epsilon_now);
         3:       return ELEV_W'(epsilon_now) + 1;
         4:       return $urandom();
         default: return $urandom_range(0, 200000);
      endcase
   endfunction

   function automatic logic [SHARE_W-1:0] pick_share();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h0001_0000;
         3, 4, 5: return $urandom();
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   // Offers one request transaction and returns after it is accepted.
   task automatic send_item(input neighbor_item_t item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.center_elevation <= item.center_elevation;
      req_ch.center_sat_deficit <= item.center_sat_deficit;
      req_ch.neighbor_elevation <= item.neighbor_elevation;
      req_ch.neighbor_sat_deficit <= item.neighbor_sat_deficit;
      req_ch.neighbor_share <= item.neighbor_share;
      req_ch.total_share <= item.total_share;
      req_ch.last_neighbor <= item.last_neighbor;
      req_ch.no_neighbors <= item.no_neighbors;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Stops offering requests until every predicted response has arrived and
   // the unit has had time to finish any neighbour that produces no response.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_epsilon(input logic [EPS_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.elevation_epsilon <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      epsilon_now = value;
   endtask

   // Random traffic: mostly well-formed patches, some lone patches and noise.
   task automatic run_phase(input int goal, input int hold_at, input int pause_at);
      int                       start;
      int                       count;
      logic signed [ELEV_W-1:0] cz;
      logic signed [ELEV_W-1:0] cd;
      logic [SHARE_W-1:0]       ts;
      start = items_sent;
      while (items_sent - start < goal) begin
         if (hold_at >= 0 && items_sent - start >= hold_at) begin
            hold_len = LONG_HOLD_CYCLES;
            hold_start = 1'b1;
            hold_at = -1;
         end
         if (pause_at >= 0 && items_sent - start >= pause_at) begin
            wait_for_results();
            pause_at = -1;
         end
         case ($urandom_range(19))
            0: send_item(make_item($urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom(), pick_share(), $urandom_range(1), 1'b1));
            1, 2: send_item(make_item($urandom(), $urandom(), $urandom(), $urandom(),
                                      $urandom(), $urandom(), $urandom_range(1), 1'b0));
            default: begin
               cz = pick_elevation();
               cd = pick_deficit();
               ts = pick_share();
               count = $urandom_range(1, 6);
               for (int k = 0; k < count; k++) begin
                  // Now and then a lone patch cuts into an unfinished one.
                  if (k < count - 1 && $urandom_range(24) == 0)
                     send_item(make_item($urandom(), $urandom(), $urandom(), $urandom(),
                                         $urandom(), pick_share(), 1'b0, 1'b1));
                  send_item(make_item(cz, cd, near_elevation(cz), pick_deficit(),
                                      pick_share(), ts, k == count - 1, 1'b0));
               end
            end
         endcase
      end
   endtask

   // Main stimulus sequence.
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.center_elevation = '0;
      req_ch.center_sat_deficit = '0;
      req_ch.neighbor_elevation = '0;
      req_ch.neighbor_sat_deficit = '0;
      req_ch.neighbor_share = '0;
      req_ch.total_share = '0;
      req_ch.last_neighbor = 1'b0;
      req_ch.no_neighbors = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.elevation_epsilon = '0;
      hold_len = 0;
      hold_start = 1'b0;
      items_sent = 0;
      epsilon_now = EPS_RESET;
      send_idle_pct = 23;
      recv_idle_pct = 81;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed transactions with the reset epsilon of one.
      // Lone patches pass the total share through.
      send_item(make_item(32'sh7FFF_FFFF, -1, 32'sh8000_0000, 5, '1, '1, 1'b1, 1'b1));
      send_item(make_item(0, 0, 0, 0, 0, '0, 1'b0, 1'b1));
      // Unit gradient, then flat and just-steep-enough neighbours.
      send_item(make_item(4096, 0, 0, 0, 32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      send_item(make_item(100, 0, 99, 0, 32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      send_item(make_item(100, 0, 98, 0, 32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      // Deficit at the epsilon is ignored, one above it counts.
      send_item(make_item(1000, 1, 0, 2, 32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      // Gradient against the slope, zero gradient, downhill on both.
      send_item(make_item(1000, 5000, 0, 0, 32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      send_item(make_item(1000, 1000, 0, 0, 32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      send_item(make_item(0, 0, 2000, 0, 32'h8000, 32'h2_0000, 1'b1, 1'b0));
      send_item(make_item(3000, -1000000, 0, -5, 32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      send_item(make_item(4096, 0, 0, 0, '0, 32'h1_0000, 1'b1, 1'b0));
      // Ratio clip, term clip, sum clip and final product clip.
      send_item(make_item(32'sh7FFF_FFFF, 2, 32'sh7FFF_FFFD, 32'sh7FFF_FFFF,
                          32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      send_item(make_item(2, -5, 0, 32'sh0100_0000, '1, 32'h1_0000, 1'b1, 1'b0));
      send_item(make_item(2, -5, 0, 32'sh0100_0000, 32'h1_8000, 32'h100, 1'b0, 1'b0));
      send_item(make_item(2, -5, 0, 32'sh0100_0000, 32'h1_8000, 32'h100, 1'b1, 1'b0));
      send_item(make_item(4096, 0, 0, 0, '1, '1, 1'b1, 1'b0));
      // Widest elevation difference.
      send_item(make_item(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0,
                          32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      // A lone patch discards a partial sum.
      send_item(make_item(4096, 0, 0, 0, 32'h1_0000, 32'h1_0000, 1'b0, 1'b0));
      send_item(make_item(4096, 0, 0, 0, 32'h1_0000, 32'h1_0000, 1'b0, 1'b0));
      send_item(make_item(0, 0, 0, 0, 0, 32'h1234_5678, 1'b0, 1'b1));
      send_item(make_item(4096, 0, 2048, 0, 32'h1_0000, 32'h1_0000, 1'b1, 1'b0));
      // Three neighbours summed into one response.
      send_item(make_item(8192, 0, 0, 0, 32'h8000, 32'h3_0000, 1'b0, 1'b0));
      send_item(make_item(8192, 0, 4096, 0, 32'h4000, 32'h3_0000, 1'b0, 1'b0));
      send_item(make_item(8192, 0, 12288, 0, 32'h1_0000, 32'h3_0000, 1'b1, 1'b0));
      wait_for_results();

      // Random phases across epsilon settings and idle patterns.
      write_epsilon('0);
      run_phase(142, -1, -1);
      wait_for_results();
      write_epsilon('1);
      run_phase(142, -1, -1);
      wait_for_results();

      send_idle_pct = 81;
      recv_idle_pct = 23;
      write_epsilon(EPS_W'($urandom_range(2, 4096)));
      run_phase(142, -1, 70);
      wait_for_results();
      write_epsilon(EPS_RESET);
      run_phase(142, -1, -1);
      wait_for_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_epsilon(16'd300);
      run_phase(142, 10, -1);
      wait_for_results();
      write_epsilon(EPS_W'($urandom()));
      run_phase(142, -1, -1);
      wait_for_results();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
